>>> sv/dste_pkg.sv
// ----------------------------------------------------------------------------
// dste_pkg: shared constants and codes for the disk seek time estimator
// Field widths, register indexes, direction codes and scheme codes.
// ----------------------------------------------------------------------------
package dste_pkg;

  // Fixed widths of the channel and configuration fields.
  localparam int CYL_FIELD_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DIR_BITS       = 2;
  localparam int SEEK_BITS      = 16;
  localparam int TIME_BITS      = 48;
  localparam int SCHEME_BITS    = 2;

  // Defaults for the top-level parameters.
  localparam int CYLINDER_BITS_DEFAULT = 16;
  localparam int DISTANCE_BITS_DEFAULT = 32;

  // Register values after reset.
  localparam logic [CFG_DATA_BITS-1:0] START_RESET = 16'd0;
  localparam logic [CFG_DATA_BITS-1:0] END_RESET   = 16'd199;
  localparam logic [SEEK_BITS-1:0]     SEEK_RESET  = 16'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_CYLINDER    = 3'd0,
    REG_END_CYLINDER      = 3'd1,
    REG_SCAN_DIRECTION    = 3'd2,
    REG_CSCAN_DIRECTION   = 3'd3,
    REG_SEEK_PER_CYLINDER = 3'd4
  } cfg_reg_t;

  // Sweep direction codes; the two unused codes mean no valid sweep.
  localparam logic [DIR_BITS-1:0] DIR_TO_ZERO     = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_TO_END      = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_UNUSED_LOW  = 2'd2;
  localparam logic [DIR_BITS-1:0] DIR_UNUSED_HIGH = 2'd3;

  // Scheme codes reported as the best choice.
  typedef enum logic [SCHEME_BITS-1:0] {
    SCHEME_FCFS  = 2'd0,
    SCHEME_SCAN  = 2'd1,
    SCHEME_CSCAN = 2'd2
  } scheme_t;

endpackage

>>> sv/dste_if.sv
// ----------------------------------------------------------------------------
// dste_if: request and result channels of the disk seek time estimator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dste_request_if;
  logic                                valid;
  logic                                ready;
  logic [dste_pkg::CYL_FIELD_BITS-1:0] cylinder;
  logic                                last;

  modport source (output valid, output cylinder, output last, input ready);
  modport sink   (input valid, input cylinder, input last, output ready);
endinterface

interface dste_result_if;
  logic                             valid;
  logic                             ready;
  logic [dste_pkg::TIME_BITS-1:0]   fcfs_seek_time;
  logic [dste_pkg::TIME_BITS-1:0]   scan_seek_time;
  logic [dste_pkg::TIME_BITS-1:0]   cscan_seek_time;
  logic [dste_pkg::SCHEME_BITS-1:0] best_scheme;
  logic                             range_error;

  modport source (output valid, output fcfs_seek_time, output scan_seek_time,
                  output cscan_seek_time, output best_scheme, output range_error,
                  input ready);
  modport sink   (input valid, input fcfs_seek_time, input scan_seek_time,
                  input cscan_seek_time, input best_scheme, input range_error,
                  output ready);
endinterface

>>> sv/disk_seek_time_estimator.sv
// ----------------------------------------------------------------------------
// disk_seek_time_estimator: FCFS, SCAN and C-SCAN seek time of a request batch
// The block takes one cylinder request per transfer on the request channel,
// in arrival order, and may take a new request in every clock cycle. For each
// request it adds the head travel to a saturating first-come-first-served
// total and updates the minimum and maximum of the requests below the start
// cylinder and of those at or above it. The request marked last closes the
// batch: its snapshot register is loaded at the transfer itself, and the
// result moves on through the registers of the sweep distances, the multiply
// by the seek time and the best-scheme compare (the output register), after
// which the result channel holds it until it is taken. The rate of one request
// per cycle is set by the accumulate and min/max update of the batch state;
// the four result registers behind it are pipelined and only hold back
// requests when the result channel stalls long enough to fill all of them.
// The SCAN and C-SCAN totals follow in closed form from the
// extremes, the end cylinder and each direction code, so no sorting is done;
// an unrecognized direction code gives that scheme zero. A start cylinder
// beyond the end cylinder yields range_error with all times zero. Distances
// saturate at DISTANCE_BITS ones and times at 48 ones. Configuration writes
// take effect at once and are meant to be made while no batch is in flight.
// ----------------------------------------------------------------------------
module disk_seek_time_estimator #(
  parameter int CYLINDER_BITS = dste_pkg::CYLINDER_BITS_DEFAULT,
  parameter int DISTANCE_BITS = dste_pkg::DISTANCE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [dste_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dste_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  dste_request_if.sink                        request,
  dste_result_if.source                       result
);

  localparam int CB = CYLINDER_BITS;
  localparam int DB = DISTANCE_BITS;
  localparam int TB = dste_pkg::TIME_BITS;
  localparam int SB = dste_pkg::SEEK_BITS;
  // Width of the running FCFS sum before saturation.
  localparam int FW = ((DB > CB) ? DB : CB) + 1;
  // Width of a raw sweep distance: at most three cylinder spans.
  localparam int XW = CB + 2;
  // Width in which a raw sweep distance is compared against the limit.
  localparam int QW = (XW > DB) ? XW : DB;
  // Width of the time product, at least one bit above the time limit.
  localparam int MW = ((DB + SB) > TB) ? (DB + SB) : (TB + 1);

  localparam logic [FW-1:0] FCFS_LIMIT  = FW'({DB{1'b1}});
  localparam logic [QW-1:0] SWEEP_LIMIT = QW'({DB{1'b1}});
  localparam logic [MW-1:0] TIME_LIMIT  = MW'({TB{1'b1}});

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [dste_pkg::CFG_DATA_BITS-1:0] start_cylinder;
  logic [dste_pkg::CFG_DATA_BITS-1:0] end_cylinder;
  logic [dste_pkg::DIR_BITS-1:0]      scan_direction;
  logic [dste_pkg::DIR_BITS-1:0]      cscan_direction;
  logic [SB-1:0]                      seek_per_cylinder;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cylinder    <= dste_pkg::START_RESET;
      end_cylinder      <= dste_pkg::END_RESET;
      scan_direction    <= dste_pkg::DIR_TO_ZERO;
      cscan_direction   <= dste_pkg::DIR_TO_ZERO;
      seek_per_cylinder <= dste_pkg::SEEK_RESET;
    end else if (cfg_write_enable) begin
      unique case (dste_pkg::cfg_reg_t'(cfg_index))
        dste_pkg::REG_START_CYLINDER:    start_cylinder    <= cfg_data;
        dste_pkg::REG_END_CYLINDER:      end_cylinder      <= cfg_data;
        dste_pkg::REG_SCAN_DIRECTION:    scan_direction    <= cfg_data[dste_pkg::DIR_BITS-1:0];
        dste_pkg::REG_CSCAN_DIRECTION:   cscan_direction   <= cfg_data[dste_pkg::DIR_BITS-1:0];
        dste_pkg::REG_SEEK_PER_CYLINDER: seek_per_cylinder <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  // Cylinder values as the datapath sees them.
  logic [CB-1:0] start_c;
  logic [CB-1:0] end_c;
  logic [CB-1:0] cyl;

  assign start_c = CB'(start_cylinder);
  assign end_c   = CB'(end_cylinder);
  assign cyl     = CB'(request.cylinder);

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or its contents
  // move on in the same cycle.
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic adv_out, adv3, adv2, adv1;
  logic fire;

  assign adv_out       = !result.valid || result.ready;
  assign adv3          = !s3_valid || adv_out;
  assign adv2          = !s2_valid || adv3;
  assign adv1          = !s1_valid || adv2;
  assign request.ready = adv1;
  assign fire          = request.valid && request.ready;

  // --------------------------------------------------------------------------
  // Batch state, updated once per request transfer
  // --------------------------------------------------------------------------
  logic          batch_open;
  logic [CB-1:0] previous_cylinder;
  logic [DB-1:0] fcfs_distance;
  logic          high_seen;
  logic [CB-1:0] high_minimum;
  logic [CB-1:0] high_maximum;
  logic          low_seen;
  logic [CB-1:0] low_minimum;
  logic [CB-1:0] low_maximum;

  logic [CB-1:0] origin;
  logic [CB-1:0] step;
  logic [FW-1:0] fcfs_sum;
  logic [DB-1:0] fcfs_distance_next;
  logic          is_low;
  logic          high_seen_next;
  logic [CB-1:0] high_minimum_next;
  logic [CB-1:0] high_maximum_next;
  logic          low_seen_next;
  logic [CB-1:0] low_minimum_next;
  logic [CB-1:0] low_maximum_next;

  always_comb begin
    // The first request of a batch travels from the start cylinder.
    origin             = batch_open ? previous_cylinder : start_c;
    step               = (cyl > origin) ? (cyl - origin) : (origin - cyl);
    fcfs_sum           = FW'(fcfs_distance) + FW'(step);
    fcfs_distance_next = (fcfs_sum > FCFS_LIMIT) ? {DB{1'b1}} : fcfs_sum[DB-1:0];

    is_low            = cyl < start_c;
    high_seen_next    = high_seen || !is_low;
    high_minimum_next = (!is_low && (cyl < high_minimum)) ? cyl : high_minimum;
    high_maximum_next = (!is_low && (cyl > high_maximum)) ? cyl : high_maximum;
    low_seen_next     = low_seen || is_low;
    low_minimum_next  = (is_low && (cyl < low_minimum)) ? cyl : low_minimum;
    low_maximum_next  = (is_low && (cyl > low_maximum)) ? cyl : low_maximum;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && request.last)) begin
      // A closed batch leaves everything as after reset.
      batch_open        <= 1'b0;
      previous_cylinder <= '0;
      fcfs_distance     <= '0;
      high_seen         <= 1'b0;
      high_minimum      <= '1;
      high_maximum      <= '0;
      low_seen          <= 1'b0;
      low_minimum       <= '1;
      low_maximum       <= '0;
    end else if (fire) begin
      batch_open        <= 1'b1;
      previous_cylinder <= cyl;
      fcfs_distance     <= fcfs_distance_next;
      high_seen         <= high_seen_next;
      high_minimum      <= high_minimum_next;
      high_maximum      <= high_maximum_next;
      low_seen          <= low_seen_next;
      low_minimum       <= low_minimum_next;
      low_maximum       <= low_maximum_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: snapshot of the closed batch and of the registers it uses
  // --------------------------------------------------------------------------
  logic [DB-1:0]                 s1_fcfs;
  logic                          s1_high_seen;
  logic [CB-1:0]                 s1_high_min;
  logic [CB-1:0]                 s1_high_max;
  logic                          s1_low_seen;
  logic [CB-1:0]                 s1_low_min;
  logic [CB-1:0]                 s1_low_max;
  logic [CB-1:0]                 s1_start;
  logic [CB-1:0]                 s1_end;
  logic [dste_pkg::DIR_BITS-1:0] s1_scan_dir;
  logic [dste_pkg::DIR_BITS-1:0] s1_cscan_dir;
  logic [SB-1:0]                 s1_seek;
  logic                          s1_range_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= fire && request.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_fcfs        <= fcfs_distance_next;
      s1_high_seen   <= high_seen_next;
      s1_high_min    <= high_minimum_next;
      s1_high_max    <= high_maximum_next;
      s1_low_seen    <= low_seen_next;
      s1_low_min     <= low_minimum_next;
      s1_low_max     <= low_maximum_next;
      s1_start       <= start_c;
      s1_end         <= end_c;
      s1_scan_dir    <= scan_direction;
      s1_cscan_dir   <= cscan_direction;
      s1_seek        <= seek_per_cylinder;
      s1_range_error <= start_c > end_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: closed-form sweep distances
  // --------------------------------------------------------------------------
  logic [CB-1:0] top;
  logic [CB-1:0] turn;
  logic [CB-1:0] top_less_start;
  logic [CB-1:0] top_less_low_min;
  logic [CB-1:0] top_less_turn;
  logic [XW-1:0] scan_raw;
  logic [XW-1:0] cscan_raw;
  logic [DB-1:0] scan_dist;
  logic [DB-1:0] cscan_dist;

  always_comb begin
    // A sweep toward the end goes up to the end stop or to the highest
    // request beyond it; the C-SCAN return lands on the lowest high request.
    top  = (s1_high_seen && (s1_high_max > s1_end)) ? s1_high_max : s1_end;
    turn = (s1_high_seen && (s1_high_min < s1_end)) ? s1_high_min : s1_end;
    top_less_start   = top - s1_start;
    top_less_low_min = top - s1_low_min;
    top_less_turn    = top - turn;

    unique case (s1_scan_dir)
      dste_pkg::DIR_TO_ZERO:
        scan_raw = XW'(s1_start) + (s1_high_seen ? XW'(s1_high_max) : '0);
      dste_pkg::DIR_TO_END:
        scan_raw = XW'(top_less_start) + (s1_low_seen ? XW'(top_less_low_min) : '0);
      default:
        scan_raw = '0;
    endcase

    unique case (s1_cscan_dir)
      dste_pkg::DIR_TO_ZERO:
        cscan_raw = XW'(s1_start) + XW'(top) + XW'(top_less_turn);
      dste_pkg::DIR_TO_END:
        cscan_raw = XW'(top_less_start) + XW'(top)
                  + (s1_low_seen ? XW'(s1_low_max) : '0);
      default:
        cscan_raw = '0;
    endcase

    scan_dist  = (QW'(scan_raw) > SWEEP_LIMIT)  ? {DB{1'b1}} : DB'(scan_raw);
    cscan_dist = (QW'(cscan_raw) > SWEEP_LIMIT) ? {DB{1'b1}} : DB'(cscan_raw);
  end

  logic [DB-1:0] s2_fcfs;
  logic [DB-1:0] s2_scan;
  logic [DB-1:0] s2_cscan;
  logic [SB-1:0] s2_seek;
  logic          s2_range_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      // A range error reports zero for every scheme.
      s2_fcfs        <= s1_range_error ? '0 : s1_fcfs;
      s2_scan        <= s1_range_error ? '0 : scan_dist;
      s2_cscan       <= s1_range_error ? '0 : cscan_dist;
      s2_seek        <= s1_seek;
      s2_range_error <= s1_range_error;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: distances times seek time, saturated to the time width
  // --------------------------------------------------------------------------
  logic [MW-1:0] fcfs_product;
  logic [MW-1:0] scan_product;
  logic [MW-1:0] cscan_product;
  logic [TB-1:0] fcfs_time;
  logic [TB-1:0] scan_time;
  logic [TB-1:0] cscan_time;

  always_comb begin
    fcfs_product  = MW'(s2_fcfs) * MW'(s2_seek);
    scan_product  = MW'(s2_scan) * MW'(s2_seek);
    cscan_product = MW'(s2_cscan) * MW'(s2_seek);
    fcfs_time  = (fcfs_product > TIME_LIMIT)  ? {TB{1'b1}} : fcfs_product[TB-1:0];
    scan_time  = (scan_product > TIME_LIMIT)  ? {TB{1'b1}} : scan_product[TB-1:0];
    cscan_time = (cscan_product > TIME_LIMIT) ? {TB{1'b1}} : cscan_product[TB-1:0];
  end

  logic [TB-1:0] s3_fcfs_time;
  logic [TB-1:0] s3_scan_time;
  logic [TB-1:0] s3_cscan_time;
  logic          s3_range_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_fcfs_time   <= fcfs_time;
      s3_scan_time   <= scan_time;
      s3_cscan_time  <= cscan_time;
      s3_range_error <= s2_range_error;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: best scheme, ties going to FCFS and then to SCAN
  // --------------------------------------------------------------------------
  logic              scan_wins;
  logic [TB-1:0]     runner_time;
  dste_pkg::scheme_t best;

  always_comb begin
    scan_wins   = s3_scan_time < s3_fcfs_time;
    runner_time = scan_wins ? s3_scan_time : s3_fcfs_time;
    priority if (s3_cscan_time < runner_time) begin
      best = dste_pkg::SCHEME_CSCAN;
    end else if (scan_wins) begin
      best = dste_pkg::SCHEME_SCAN;
    end else begin
      best = dste_pkg::SCHEME_FCFS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv_out) begin
      result.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      result.fcfs_seek_time  <= s3_fcfs_time;
      result.scan_seek_time  <= s3_scan_time;
      result.cscan_seek_time <= s3_cscan_time;
      result.best_scheme     <= best;
      result.range_error     <= s3_range_error;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A range error result carries zero times and reports FCFS.
  range_error_zero_a: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.range_error) |->
      (result.fcfs_seek_time == '0 && result.scan_seek_time == '0 &&
       result.cscan_seek_time == '0 && result.best_scheme == dste_pkg::SCHEME_FCFS))
    else $error("range error result with nonzero times or scheme");

  // SCAN is reported only when it beats FCFS and does not lose to C-SCAN.
  scan_best_a: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.best_scheme == dste_pkg::SCHEME_SCAN) |->
      (result.scan_seek_time < result.fcfs_seek_time &&
       result.scan_seek_time <= result.cscan_seek_time))
    else $error("SCAN reported best but is not the cheapest");

  // Requests are held back only when every result stage is occupied.
  ready_full_a: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> (s1_valid && s2_valid && s3_valid && result.valid))
    else $error("request stalled with a free result stage");

  // The transfer of a last request closes the batch.
  batch_close_a: assert property (@(posedge clk) disable iff (rst)
    (fire && request.last) |=> !batch_open)
    else $error("batch still open after its last request");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the disk seek time estimator
// Sends batches of cylinder requests over the request channel, predicts the
// FCFS, SCAN and C-SCAN seek times of every closed batch, and compares each
// result transfer against the oldest prediction. Directed batches come first,
// then random batches under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;

  // The block is built with its default parameters, so the predictor uses them.
  localparam int          DIST_BITS    = dste_pkg::DISTANCE_BITS_DEFAULT;
  localparam logic [63:0] DIST_MAX     = (64'd1 << DIST_BITS) - 64'd1;
  localparam logic [63:0] TIME_MAX     = (64'd1 << dste_pkg::TIME_BITS) - 64'd1;
  localparam logic [15:0] CYL_TOP      = 16'hFFFF;
  // Extra wait after the last result, so that the pipeline is surely empty.
  localparam int          DRAIN_CYCLES = 8;
  // Generous ceiling; a correct run needs a small fraction of it.
  localparam int          CYCLE_LIMIT  = 400000;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [dste_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
  localparam int          RANDOM_SEGMENTS      = 6;
  localparam int          ITEMS_PER_SEGMENT    = 50;

  // One result of a closed batch, field by field.
  typedef struct packed {
    logic [dste_pkg::TIME_BITS-1:0]   fcfs;
    logic [dste_pkg::TIME_BITS-1:0]   scan;
    logic [dste_pkg::TIME_BITS-1:0]   cscan;
    logic [dste_pkg::SCHEME_BITS-1:0] best;
    logic                             range_error;
  } seek_times_t;

  // Keeps a shadow of the registers and the batch state, computes the seek
  // times of each batch when its last request is taken, and checks results.
  class seek_time_tracker;
    logic [15:0]   start_cyl;
    logic [15:0]   end_cyl;
    logic [1:0]    scan_dir;
    logic [1:0]    cscan_dir;
    logic [15:0]   seek_step;
    bit            batch_open;
    bit            high_seen;
    bit            low_seen;
    logic [15:0]   prev_cyl;
    logic [15:0]   high_min;
    logic [15:0]   high_max;
    logic [15:0]   low_min;
    logic [15:0]   low_max;
    logic [63:0]   fcfs_dist;
    seek_times_t   expected_times[$];
    int            mismatches;

    function new();
      start_cyl  = dste_pkg::START_RESET;
      end_cyl    = dste_pkg::END_RESET;
      scan_dir   = dste_pkg::DIR_TO_ZERO;
      cscan_dir  = dste_pkg::DIR_TO_ZERO;
      seek_step  = dste_pkg::SEEK_RESET;
      mismatches = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      batch_open = 0;
      prev_cyl   = '0;
      fcfs_dist  = '0;
      high_seen  = 0;
      high_min   = CYL_TOP;
      high_max   = '0;
      low_seen   = 0;
      low_min    = CYL_TOP;
      low_max    = '0;
    endfunction

    function void apply_config(logic [dste_pkg::CFG_INDEX_BITS-1:0] idx,
                               logic [15:0] value);
      case (idx)
        dste_pkg::REG_START_CYLINDER:    start_cyl = value;
        dste_pkg::REG_END_CYLINDER:      end_cyl   = value;
        dste_pkg::REG_SCAN_DIRECTION:    scan_dir  = value[1:0];
        dste_pkg::REG_CSCAN_DIRECTION:   cscan_dir = value[1:0];
        dste_pkg::REG_SEEK_PER_CYLINDER: seek_step = value;
        default: ;
      endcase
    endfunction

    function logic [63:0] clamp_distance(logic [63:0] d);
      return (d > DIST_MAX) ? DIST_MAX : d;
    endfunction

    function logic [dste_pkg::TIME_BITS-1:0] scale_time(logic [63:0] d);
      logic [63:0] product;
      if (seek_step != 0 && d > TIME_MAX / 64'(seek_step))
        return TIME_MAX[dste_pkg::TIME_BITS-1:0];
      product = d * 64'(seek_step);
      return product[dste_pkg::TIME_BITS-1:0];
    endfunction

    function void note_request(logic [15:0] cyl, logic last);
      logic [63:0] top;
      logic [63:0] rmin;
      logic [63:0] dscan;
      logic [63:0] dcscan;
      seek_times_t t;
      if (!batch_open) begin
        prev_cyl   = start_cyl;
        batch_open = 1;
      end
      fcfs_dist = clamp_distance(fcfs_dist +
                                 ((cyl > prev_cyl) ? 64'(cyl - prev_cyl) : 64'(prev_cyl - cyl)));
      prev_cyl = cyl;
      if (cyl < start_cyl) begin
        low_seen = 1;
        if (cyl < low_min) low_min = cyl;
        if (cyl > low_max) low_max = cyl;
      end else begin
        high_seen = 1;
        if (cyl < high_min) high_min = cyl;
        if (cyl > high_max) high_max = cyl;
      end
      if (!last) return;

      t = '0;
      if (start_cyl > end_cyl) begin
        t.best        = dste_pkg::SCHEME_FCFS;
        t.range_error = 1'b1;
      end else begin
        top  = (high_seen && high_max > end_cyl) ? 64'(high_max) : 64'(end_cyl);
        rmin = (high_seen && high_min < end_cyl) ? 64'(high_min) : 64'(end_cyl);
        if (scan_dir == dste_pkg::DIR_TO_ZERO)
          dscan = 64'(start_cyl) + (high_seen ? 64'(high_max) : 64'd0);
        else if (scan_dir == dste_pkg::DIR_TO_END)
          dscan = (top - 64'(start_cyl)) + (low_seen ? top - 64'(low_min) : 64'd0);
        else
          dscan = '0;
        if (cscan_dir == dste_pkg::DIR_TO_ZERO)
          dcscan = 64'(start_cyl) + top + (top - rmin);
        else if (cscan_dir == dste_pkg::DIR_TO_END)
          dcscan = (top - 64'(start_cyl)) + top + (low_seen ? 64'(low_max) : 64'd0);
        else
          dcscan = '0;
        t.fcfs  = scale_time(fcfs_dist);
        t.scan  = scale_time(clamp_distance(dscan));
        t.cscan = scale_time(clamp_distance(dcscan));
        t.best  = dste_pkg::SCHEME_FCFS;
        if (t.scan < t.fcfs) t.best = dste_pkg::SCHEME_SCAN;
        if (t.cscan < ((t.best == dste_pkg::SCHEME_SCAN) ? t.scan : t.fcfs))
          t.best = dste_pkg::SCHEME_CSCAN;
      end
      expected_times.push_back(t);
      clear_batch();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check_result(seek_times_t got);
      seek_times_t want;
      if (expected_times.size() == 0) begin
        report_mismatch("result with no batch pending", 64'(got.fcfs), 64'd0);
        return;
      end
      want = expected_times.pop_front();
      if (got.fcfs != want.fcfs)
        report_mismatch("fcfs_seek_time", 64'(got.fcfs), 64'(want.fcfs));
      if (got.scan != want.scan)
        report_mismatch("scan_seek_time", 64'(got.scan), 64'(want.scan));
      if (got.cscan != want.cscan)
        report_mismatch("cscan_seek_time", 64'(got.cscan), 64'(want.cscan));
      if (got.best != want.best)
        report_mismatch("best_scheme", 64'(got.best), 64'(want.best));
      if (got.range_error != want.range_error)
        report_mismatch("range_error", 64'(got.range_error), 64'(want.range_error));
    endtask

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                                cfg_write_enable = 1'b0;
  logic [dste_pkg::CFG_INDEX_BITS-1:0] cfg_index        = '0;
  logic [dste_pkg::CFG_DATA_BITS-1:0]  cfg_data         = '0;

  dste_request_if request ();
  dste_result_if  result ();

  seek_time_tracker tracker;

  // Percentages that steer the sender gaps and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  always #10 clk = ~clk;

  disk_seek_time_estimator u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .request          (request),
    .result           (result)
  );

  // The receiver stalls at random; the chance is set per phase.
  always @(posedge clk) begin
    result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: everything is sampled at the rising edge, before any of the
  // nonblocking updates of that edge land, so the order of processes within
  // the time step does not matter. Register writes, request transfers and
  // result transfers all feed the tracker here and nowhere else.
  always @(posedge clk) begin
    seek_times_t got;
    if (!rst) begin
      if (cfg_write_enable) tracker.apply_config(cfg_index, cfg_data);
      if (request.valid && request.ready) tracker.note_request(request.cylinder, request.last);
      if (result.valid && result.ready) begin
        got.fcfs        = result.fcfs_seek_time;
        got.scan        = result.scan_seek_time;
        got.cscan       = result.cscan_seek_time;
        got.best        = result.best_scheme;
        got.range_error = result.range_error;
        tracker.check_result(got);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** disk_seek_time_estimator: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Every one of them is entered just after a rising edge and
  // returns just after one, so each signal gets at most one nonblocking
  // assignment per time step.
  // --------------------------------------------------------------------------

  // One request transfer, preceded by a random number of idle cycles. Valid
  // is left high on return so that back-to-back requests need no dip.
  task automatic send_request(input logic [15:0] cyl, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid    <= 1'b1;
    request.cylinder <= cyl;
    request.last     <= last;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  // Holds the sender off until every predicted result has come back. The
  // first edge lets the monitor see a transfer made on the previous edge.
  task automatic wait_for_results();
    request.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Before a register write the pipeline must be empty, including any
  // stage still busy after the last result has been taken.
  task automatic settle();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [dste_pkg::CFG_INDEX_BITS-1:0] idx,
                                input logic [dste_pkg::CFG_DATA_BITS-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(posedge clk);
  endtask

  // Writes all five registers. The direction registers only keep two bits,
  // so the unused upper data bits carry noise. Now and then an index past
  // the last register is written as well; it must leave everything alone.
  task automatic program_registers(input logic [15:0] start_c, input logic [15:0] end_c,
                                   input logic [1:0] scan_d, input logic [1:0] cscan_d,
                                   input logic [15:0] seek_c);
    logic [13:0] noise_a;
    logic [13:0] noise_b;
    noise_a = 14'($urandom);
    noise_b = 14'($urandom);
    settle();
    write_register(dste_pkg::REG_START_CYLINDER, start_c);
    write_register(dste_pkg::REG_END_CYLINDER, end_c);
    write_register(dste_pkg::REG_SCAN_DIRECTION, {noise_a, scan_d});
    write_register(dste_pkg::REG_CSCAN_DIRECTION, {noise_b, cscan_d});
    write_register(dste_pkg::REG_SEEK_PER_CYLINDER, seek_c);
    if ($urandom_range(0, 3) == 0)
      write_register(REG_SPARE_FIRST + 3'($urandom_range(0, 2)), 16'($urandom));
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // Direction codes lean toward the two real sweeps; the unused codes are rarer.
  function automatic logic [1:0] pick_direction();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return dste_pkg::DIR_TO_ZERO;
    if (r < 8) return dste_pkg::DIR_TO_END;
    return (r == 8) ? dste_pkg::DIR_UNUSED_LOW : dste_pkg::DIR_UNUSED_HIGH;
  endfunction

  // Random register set with the extremes given a fair share. About one
  // setting in seven puts the start beyond the end to raise the range error.
  task automatic random_registers();
    logic [15:0] end_c;
    logic [15:0] start_c;
    logic [15:0] seek_c;
    case ($urandom_range(0, 5))
      0:       end_c = '0;
      1:       end_c = CYL_TOP;
      2:       end_c = dste_pkg::END_RESET;
      default: end_c = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       start_c = '0;
      1:       start_c = end_c;
      2:       start_c = 16'($urandom);
      3:       start_c = CYL_TOP;
      default: start_c = 16'($urandom_range(0, end_c));
    endcase
    case ($urandom_range(0, 7))
      0:       seek_c = '0;
      1:       seek_c = 16'd1;
      2:       seek_c = 16'hFFFF;
      3:       seek_c = 16'($urandom);
      default: seek_c = 16'($urandom_range(1, 100));
    endcase
    program_registers(start_c, end_c, pick_direction(), pick_direction(), seek_c);
  endtask

  // Cylinders cluster around the start and end cylinders, where the low/high
  // split and the end stop are decided, with the rest spread over the field.
  function automatic logic [15:0] pick_cylinder();
    logic [15:0] base_s;
    logic [15:0] base_e;
    base_s = tracker.start_cyl;
    base_e = tracker.end_cyl;
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CYL_TOP;
      2:       return base_s;
      3:       return base_e;
      4:       return base_s - 16'd1;
      5:       return base_e + 16'd1;
      6, 7:    return base_s + 16'($urandom_range(0, 64)) - 16'd32;
      8:       return 16'($urandom_range(0, base_e));
      default: return 16'($urandom);
    endcase
  endfunction

  // Batches are mostly short so that many results come out; a few are long.
  function automatic int pick_batch_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 6);
    if (r < 19) return $urandom_range(7, 20);
    return $urandom_range(21, 60);
  endfunction

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_request(pick_cylinder(), i == len - 1);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int sent;
    request.valid    = 1'b0;
    request.cylinder = '0;
    request.last     = 1'b0;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first two batches run on the register values after
    // reset: a lone request at cylinder zero, then a batch whose requests go
    // past the end cylinder so the sweeps must stop at the highest request.
    send_request(16'd0, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd199, 1'b0);
    send_request(16'd5, 1'b1);

    // Both sweeps toward the end, with requests on either side of the start.
    program_registers(16'd100, 16'd199, dste_pkg::DIR_TO_END, dste_pkg::DIR_TO_END, 16'd3);
    send_request(16'd150, 1'b0);
    send_request(16'd20, 1'b0);
    send_request(16'd199, 1'b0);
    send_request(16'd100, 1'b1);

    // Unrecognized direction codes give those schemes zero travel.
    program_registers(16'd100, 16'd199, dste_pkg::DIR_UNUSED_LOW, dste_pkg::DIR_UNUSED_HIGH,
                      16'd3);
    send_request(16'd50, 1'b0);
    send_request(16'd180, 1'b1);

    // Largest seek time per cylinder, alternating bit patterns.
    program_registers(16'd0, 16'hFFFF, dste_pkg::DIR_TO_ZERO, dste_pkg::DIR_TO_ZERO, 16'hFFFF);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b1);

    // Start beyond the end: range error, all times zero.
    program_registers(16'd500, 16'd400, dste_pkg::DIR_TO_END, dste_pkg::DIR_TO_ZERO, 16'd2);
    send_request(16'd300, 1'b0);
    send_request(16'd600, 1'b1);

    // Everything at the top of the field, with a zero seek time so all
    // three times tie at zero and the tie goes to FCFS.
    program_registers(16'hFFFF, 16'hFFFF, dste_pkg::DIR_TO_END, dste_pkg::DIR_TO_END, 16'd0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b1);

    // A disk of one cylinder.
    program_registers(16'd0, 16'd0, dste_pkg::DIR_TO_ZERO, dste_pkg::DIR_TO_ZERO, 16'd1);
    send_request(16'd0, 1'b1);

    // Mixed directions with requests just below, at and beyond the bounds.
    program_registers(16'd1000, 16'd2000, dste_pkg::DIR_TO_ZERO, dste_pkg::DIR_TO_END, 16'd7);
    send_request(16'd999, 1'b0);
    send_request(16'd1000, 1'b0);
    send_request(16'd3000, 1'b0);
    send_request(16'd1, 1'b1);

    // Random part: four idle/stall mixes, each with several register sets.
    // Now and then the sender holds off until every result is back, so that
    // a batch also starts into a fully drained pipeline.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
        random_registers();
        sent = 0;
        while (sent < ITEMS_PER_SEGMENT) begin
          int len;
          len = pick_batch_length();
          send_batch(len);
          sent += len;
          if ($urandom_range(0, 19) == 0) wait_for_results();
        end
      end
    end

    // Drain: every batch is closed, so wait for the last results and then let
    // the pipeline drain further so that anything unexpected can show up.
    settle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("** disk_seek_time_estimator: PASSED **");
    end else begin
      $display("** disk_seek_time_estimator: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
sv/dste_pkg.sv
sv/dste_if.sv
sv/disk_seek_time_estimator.sv
tb/tb.sv
